[rtl/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Payload types, symbol and status codes, and the controller/datapath
// command and status bundles of the haplotype string clusterer.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Base symbols
  localparam logic [2:0] SYM_UNKNOWN = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_MERGED = 2'd0;
  localparam logic [1:0] ST_NEW    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Saturation limits
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int          AGREE_MAX = 511;

  typedef struct packed {
    logic [7:0]  snp_pos;
    logic [2:0]  base;
    logic        last_of_read;
    logic [31:0] read_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  hap_slot;
    logic [15:0] hap_reads;
    logic [8:0]  agree_sites;
    logic [31:0] echo_tag;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic ol_rd;      // read order list at rank counter, restart site walk
    logic take_slot;  // latch slot of current rank
    logic cmp_site;   // issue one compare site read
    logic rank_chk;   // score current rank, advance rank
    logic decide;     // pick merge, new or full
    logic row_step;   // issue one merge/copy site
    logic cnt_rd;     // read winner count and predecessor slot
    logic cnt_wr;     // write bumped count, read predecessor count
    logic cnt_cmp;    // compare counts, first swap write
    logic swap2;      // second swap write
    logic new_fin;    // finish insert of new haplotype
    logic load;       // load result register
    logic clr;        // clear one read buffer site
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic site_last;
    logic rank_end;
    logic found;
    logic full;
    logic swap;
    logic out_free;
  } sts_t;

endpackage

[rtl/hsc_ctrl.sv]
// ----------------------------------------------------------------------------
// hsc_ctrl
// Sequencer: load read, walk haplotypes, merge or insert unless full, report, clear.
// ----------------------------------------------------------------------------
module hsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  hsc_pkg::sts_t sts,
  output hsc_pkg::cmd_t cmd
);

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_RANK     = 5'd2;
  localparam logic [4:0] S_OL_RD    = 5'd3;
  localparam logic [4:0] S_SLOT     = 5'd4;
  localparam logic [4:0] S_CMP      = 5'd5;
  localparam logic [4:0] S_CMP_END  = 5'd6;
  localparam logic [4:0] S_RANK_CHK = 5'd7;
  localparam logic [4:0] S_DECIDE   = 5'd8;
  localparam logic [4:0] S_ROW      = 5'd9;
  localparam logic [4:0] S_ROW_END  = 5'd10;
  localparam logic [4:0] S_C_RD     = 5'd11;
  localparam logic [4:0] S_C_WR     = 5'd12;
  localparam logic [4:0] S_C_CMP    = 5'd13;
  localparam logic [4:0] S_SWAP2    = 5'd14;
  localparam logic [4:0] S_N_FIN    = 5'd15;
  localparam logic [4:0] S_RESULT   = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.site_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) state_next = S_RANK;
      end
      S_RANK: begin
        state_next = sts.rank_end ? S_DECIDE : S_OL_RD;
      end
      S_OL_RD: begin
        cmd.ol_rd  = 1'b1;
        state_next = S_SLOT;
      end
      S_SLOT: begin
        cmd.take_slot = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_site = 1'b1;
        if (sts.site_last) state_next = S_CMP_END;
      end
      S_CMP_END: begin
        state_next = S_RANK_CHK;
      end
      S_RANK_CHK: begin
        cmd.rank_chk = 1'b1;
        state_next   = S_RANK;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = (sts.found || !sts.full) ? S_ROW : S_RESULT;
      end
      S_ROW: begin
        cmd.row_step = 1'b1;
        if (sts.site_last) state_next = S_ROW_END;
      end
      S_ROW_END: begin
        state_next = sts.found ? S_C_RD : S_N_FIN;
      end
      S_C_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = S_C_WR;
      end
      S_C_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = S_C_CMP;
      end
      S_C_CMP: begin
        cmd.cnt_cmp = 1'b1;
        state_next  = sts.swap ? S_SWAP2 : S_RESULT;
      end
      S_SWAP2: begin
        cmd.swap2  = 1'b1;
        state_next = S_RESULT;
      end
      S_N_FIN: begin
        cmd.new_fin = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_CLR;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

endmodule

[rtl/hsc_dpath.sv]
// ----------------------------------------------------------------------------
// hsc_dpath
// Read buffer, haplotype symbol memory, counts, order list, site and rank
// counters, scoring and the result register.
// ----------------------------------------------------------------------------
module hsc_dpath #(
  parameter int MAX_HAPS  = 64,
  parameter int MAX_SITES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  hsc_pkg::cmd_t     cmd,
  output hsc_pkg::sts_t     sts,
  input  hsc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsc_pkg::out_item_t out_data
);

  localparam int HW = $clog2(MAX_HAPS);
  localparam int SW = $clog2(MAX_SITES);
  localparam int AW = $clog2(MAX_SITES + 1);

  // Memories
  logic [2:0]  hap_mem [MAX_HAPS * (2 ** SW)];
  logic [2:0]  rbuf    [MAX_SITES];
  logic [15:0] cnt_mem [MAX_HAPS];
  logic [HW-1:0] ol_mem [MAX_HAPS];

  logic [2:0]    hap_q;
  logic [2:0]    buf_q;
  logic [15:0]   cnt_q;
  logic [HW-1:0] ol_q;

  // Counters and working registers
  logic [SW-1:0] site;
  logic [SW-1:0] site_d;
  logic          pv;
  logic          pw;
  logic [HW:0]   rank;
  logic [HW:0]   used;
  logic [HW-1:0] cur_slot;
  logic [AW-1:0] agree;
  logic          ok;
  logic [AW-1:0] best_agree;
  logic [HW-1:0] best_rank;
  logic [HW-1:0] best_slot;
  logic          found;
  logic [HW-1:0] tgt;
  logic [HW-1:0] tgt_rank;
  logic [1:0]    kind;
  logic [15:0]   cnt_new;
  logic [HW-1:0] prev;
  logic [31:0]   tag;

  logic          site_last;
  logic [2:0]    in_sym;
  logic          in_wr;
  logic [HW-1:0] rank_m1;

  function automatic logic [HW-1:0] prev_next_addr();
    return ol_q;
  endfunction

  function automatic logic [15:0] cnt_new_calc();
    return (cnt_q == hsc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
  endfunction

  assign site_last = (site == SW'(MAX_SITES - 1));
  assign in_sym    = (in_data.base > hsc_pkg::SYM_UNKNOWN) ? hsc_pkg::SYM_UNKNOWN
                                                         : in_data.base;
  assign in_wr     = cmd.accept && (32'(in_data.snp_pos) < MAX_SITES);
  assign rank_m1   = tgt_rank - HW'(1);

  assign sts.site_last = site_last;
  assign sts.rank_end  = (rank == used);
  assign sts.found     = found;
  assign sts.full      = (used == (HW+1)'(MAX_HAPS));
  assign sts.swap      = (tgt_rank != '0) && (cnt_new > cnt_q);
  assign sts.out_free  = !out_valid || out_ready;

  // Read buffer: write on transfer or clear, read by site
  always_ff @(posedge clk) begin
    if (in_wr)   rbuf[SW'(in_data.snp_pos)] <= in_sym;
    if (cmd.clr) rbuf[site] <= hsc_pkg::SYM_UNKNOWN;
    buf_q <= rbuf[site];
  end

  // Haplotype symbols: read for compare, write for merge or copy
  always_ff @(posedge clk) begin
    hap_q <= hap_mem[{cur_slot, site}];
    if (pw && (kind == hsc_pkg::ST_NEW || buf_q != hsc_pkg::SYM_UNKNOWN))
      hap_mem[{tgt, site_d}] <= buf_q;
  end

  // Read counts
  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) cnt_q <= cnt_mem[tgt];
    if (cmd.cnt_wr) cnt_q <= cnt_mem[prev_next_addr()];
    if (cmd.cnt_wr) cnt_mem[tgt] <= cnt_new_calc();
    if (cmd.new_fin) cnt_mem[tgt] <= 16'd1;
  end

  // Order list
  always_ff @(posedge clk) begin
    if (cmd.ol_rd) ol_q <= ol_mem[rank[HW-1:0]];
    if (cmd.cnt_rd) ol_q <= ol_mem[rank_m1];
    if (cmd.cnt_cmp && sts.swap) ol_mem[rank_m1] <= tgt;
    if (cmd.swap2) ol_mem[tgt_rank] <= prev;
    if (cmd.new_fin) ol_mem[tgt] <= tgt;
  end

  // Site counter and pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      site <= '0;
      pv   <= 1'b0;
      pw   <= 1'b0;
    end else begin
      pv     <= cmd.cmp_site;
      pw     <= cmd.row_step;
      site_d <= site;
      if (cmd.ol_rd || cmd.decide || cmd.load) site <= '0;
      else if (cmd.cmp_site || cmd.row_step || cmd.clr)
        site <= site_last ? '0 : site + SW'(1);
    end
  end

  // Scoring and table control
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.accept && in_data.last_of_read) begin
        tag        <= in_data.read_tag;
        rank       <= '0;
        found      <= 1'b0;
        best_agree <= '0;
      end
      if (cmd.ol_rd) begin
        agree <= '0;
        ok    <= 1'b1;
      end
      if (cmd.take_slot) cur_slot <= ol_q;
      // Accumulate agreement on returned site data
      if (pv && buf_q != hsc_pkg::SYM_UNKNOWN && hap_q != hsc_pkg::SYM_UNKNOWN) begin
        if (buf_q != hap_q) ok <= 1'b0;
        else                agree <= agree + AW'(1);
      end
      if (cmd.rank_chk) begin
        if (ok && agree > best_agree) begin
          best_agree <= agree;
          best_rank  <= rank[HW-1:0];
          best_slot  <= cur_slot;
          found      <= 1'b1;
        end
        rank <= rank + (HW+1)'(1);
      end
      if (cmd.decide) begin
        if (found) begin
          kind     <= hsc_pkg::ST_MERGED;
          tgt      <= best_slot;
          tgt_rank <= best_rank;
        end else if (!sts.full) begin
          kind <= hsc_pkg::ST_NEW;
          tgt  <= used[HW-1:0];
        end else begin
          kind <= hsc_pkg::ST_FULL;
        end
      end
      if (cmd.cnt_wr) begin
        cnt_new <= cnt_new_calc();
        prev    <= ol_q;
      end
      if (cmd.new_fin) begin
        cnt_new <= 16'd1;
        used    <= used + (HW+1)'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.status   <= kind;
      out_data.echo_tag <= tag;
      if (kind == hsc_pkg::ST_FULL) begin
        out_data.hap_slot  <= '0;
        out_data.hap_reads <= '0;
      end else begin
        out_data.hap_slot  <= 6'(tgt);
        out_data.hap_reads <= cnt_new;
      end
      if (kind == hsc_pkg::ST_MERGED)
        out_data.agree_sites <= (32'(best_agree) > hsc_pkg::AGREE_MAX) ? 9'd511
                                                                     : 9'(best_agree);
      else
        out_data.agree_sites <= '0;
    end
  end

endmodule

[rtl/haplotype_string_clusterer.sv]
// ----------------------------------------------------------------------------
// haplotype_string_clusterer
// Groups reads by SNP bases into haplotypes; one result per closed read.
// ----------------------------------------------------------------------------
// Non-final bases are taken while the block is idle; a closing base starts a
//   site-serial walk over the haplotype memory, and then the read buffer is
//   cleared site by site.
// Throughput: one read at a time; bases of the next read wait for the clear.
// Reset: synchronous; empties the table and clears the read buffer site by
//   site before the first transfer.
module haplotype_string_clusterer #(
  parameter int MAX_HAPS  = 64,
  parameter int MAX_SITES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsc_pkg::out_item_t out_data
);

  hsc_pkg::cmd_t cmd;
  hsc_pkg::sts_t sts;

  hsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_of_read),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsc_dpath #(
    .MAX_HAPS  (MAX_HAPS),
    .MAX_SITES (MAX_SITES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[bench/haplotype_string_clusterer_tb.sv]
// ----------------------------------------------------------------------------
// haplotype_string_clusterer_tb
// Self-checking bench for the haplotype string clusterer. Reads are streamed
// base by base; an in-bench haplotype table predicts the placement of every
// closed read (merge, new haplotype or table full) and each result transfer
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module haplotype_string_clusterer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NHAPS  = 64;
  localparam int NSITES = 256;
  localparam int LIMIT  = 50_000_000;
  localparam int NTMPL  = 6;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  hsc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  hsc_pkg::out_item_t out_data;

  haplotype_string_clusterer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted table state
  logic [2:0]  hap_sym [NHAPS][NSITES];
  logic [15:0] hap_cnt [NHAPS];
  logic [5:0]  rank_slot [NHAPS];
  int          n_used;
  logic [2:0]  read_buf [NSITES];

  hsc_pkg::out_item_t pending_results[$];
  int          errors;
  int          burst_left;
  longint      cycles;
  logic [2:0]  tmpl [NTMPL][NSITES];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Fold one accepted base into the open read; place the read on its last base
  function automatic void place_base(hsc_pkg::in_item_t it);
    logic [2:0]         b;
    hsc_pkg::out_item_t r;
    bit                 found;
    bit                 ok;
    int                 best_rank;
    int                 best_ag;
    int                 ag;
    int                 hs;
    int                 prev;
    b = (it.base > hsc_pkg::SYM_UNKNOWN) ? hsc_pkg::SYM_UNKNOWN : it.base;
    read_buf[it.snp_pos] = b;
    if (!it.last_of_read) return;
    found = 0;
    best_rank = 0;
    best_ag = 0;
    for (int k = 0; k < n_used; k++) begin
      hs = rank_slot[k];
      ag = 0;
      ok = 1;
      for (int s = 0; s < NSITES; s++) begin
        if (read_buf[s] == hsc_pkg::SYM_UNKNOWN || hap_sym[hs][s] == hsc_pkg::SYM_UNKNOWN)
          continue;
        if (read_buf[s] != hap_sym[hs][s]) begin
          ok = 0;
          break;
        end
        ag++;
      end
      if (ok && ag > best_ag) begin
        best_ag = ag;
        best_rank = k;
        found = 1;
      end
    end
    r = '0;
    r.echo_tag = it.read_tag;
    if (found) begin
      hs = rank_slot[best_rank];
      for (int s = 0; s < NSITES; s++)
        if (read_buf[s] != hsc_pkg::SYM_UNKNOWN) hap_sym[hs][s] = read_buf[s];
      if (hap_cnt[hs] != hsc_pkg::COUNT_MAX) hap_cnt[hs]++;
      // move the winner one place forward on a strictly higher count
      if (best_rank > 0) begin
        prev = rank_slot[best_rank-1];
        if (hap_cnt[hs] > hap_cnt[prev]) begin
          rank_slot[best_rank-1] = 6'(hs);
          rank_slot[best_rank] = 6'(prev);
        end
      end
      r.status = hsc_pkg::ST_MERGED;
      r.hap_slot = 6'(hs);
      r.hap_reads = hap_cnt[hs];
      r.agree_sites = 9'((best_ag > hsc_pkg::AGREE_MAX) ? hsc_pkg::AGREE_MAX : best_ag);
    end else if (n_used < NHAPS) begin
      for (int s = 0; s < NSITES; s++) hap_sym[n_used][s] = read_buf[s];
      hap_cnt[n_used] = 1;
      rank_slot[n_used] = 6'(n_used);
      r.status = hsc_pkg::ST_NEW;
      r.hap_slot = 6'(n_used);
      r.hap_reads = 1;
      n_used++;
    end else begin
      r.status = hsc_pkg::ST_FULL;
    end
    for (int s = 0; s < NSITES; s++) read_buf[s] = hsc_pkg::SYM_UNKNOWN;
    pending_results.push_back(r);
  endfunction

  // Send one base; bursts of random length separated by random gaps
  task automatic send_base(input logic [7:0] pos, input logic [2:0] b,
                           input logic lst, input logic [31:0] tag);
    hsc_pkg::in_item_t it;
    int                gap;
    it.snp_pos = pos;
    it.base = b;
    it.last_of_read = lst;
    it.read_tag = tag;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    place_base(it);
  endtask

  // Hold off until every predicted result has been received
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NSITES + 16) @(posedge clk);
  endtask

  // Receiver stall pattern: phases of full rate, random and sparse ready
  always @(posedge clk) begin
    case ((cycles / 97) % 4)
      0, 3:    out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each result transfer with the oldest prediction
  always @(negedge clk) begin
    hsc_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.hap_slot !== e.hap_slot) begin
          $error("hap_slot: expected %0d, got %0d", e.hap_slot, out_data.hap_slot);
          errors++;
        end
        if (out_data.hap_reads !== e.hap_reads) begin
          $error("hap_reads: expected %0d, got %0d", e.hap_reads, out_data.hap_reads);
          errors++;
        end
        if (out_data.agree_sites !== e.agree_sites) begin
          $error("agree_sites: expected %0d, got %0d", e.agree_sites,
                 out_data.agree_sites);
          errors++;
        end
        if (out_data.echo_tag !== e.echo_tag) begin
          $error("echo_tag: expected %h, got %h", e.echo_tag, out_data.echo_tag);
          errors++;
        end
      end
    end
  end

  // Extremes, base codes, repeated site, empty read, merge and reorder
  task automatic test_directed();
    send_base(8'd0, 3'd0, 1'b0, 32'h0000_0000);
    send_base(8'd255, 3'd3, 1'b1, 32'hFFFF_FFFF);   // new
    send_base(8'd0, 3'd0, 1'b1, 32'h0000_0001);     // merge
    send_base(8'd10, 3'd7, 1'b1, 32'hA5A5_5A5A);    // no known base
    send_base(8'd20, 3'd1, 1'b0, 32'h0000_0002);
    send_base(8'd20, 3'd2, 1'b1, 32'h0000_0003);    // later base wins
    send_base(8'd20, 3'd2, 1'b0, 32'h0000_0004);
    send_base(8'd21, 3'd4, 1'b1, 32'h0000_0005);    // merge, move forward
    send_base(8'd0, 3'd1, 1'b1, 32'h8000_0000);     // conflict
    send_base(8'd5, 3'd6, 1'b0, 32'h0000_0006);
    send_base(8'd6, 3'd5, 1'b1, 32'h7FFF_FFFF);
    send_base(8'd128, 3'd4, 1'b0, 32'h0000_0007);
    send_base(8'd129, 3'd3, 1'b1, 32'h0000_0008);
    send_base(8'd128, 3'd4, 1'b1, 32'h0000_0009);   // merge
    drain();
  endtask

  // Reads drawn from a few template haplotypes with light noise
  task automatic test_random_reads(input int n_items);
    int         sent;
    int         len;
    int         start;
    int         t;
    logic [2:0] b;
    sent = 0;
    for (int k = 0; k < NTMPL; k++)
      for (int s = 0; s < NSITES; s++) tmpl[k][s] = 3'($urandom_range(0, 4));
    while (sent < n_items) begin
      len = $urandom_range(1, 24);
      start = $urandom_range(0, NSITES - len);
      t = $urandom_range(0, NTMPL - 1);
      for (int i = 0; i < len; i++) begin
        b = tmpl[t][start+i];
        case ($urandom_range(0, 39))
          0:       b = 3'($urandom_range(0, 4));
          1:       b = 3'($urandom_range(5, 7));
          default: ;
        endcase
        send_base(8'(start + i), b, (i == len - 1), $urandom());
        sent++;
      end
    end
    drain();
  endtask

  // Fill the table with empty reads, then overflow it
  task automatic test_table_full();
    while (n_used < NHAPS) send_base(8'($urandom()), 3'd5, 1'b1, $urandom());
    send_base(8'($urandom()), 3'd5, 1'b1, $urandom());
    send_base(8'd0, 3'd1, 1'b0, $urandom());
    send_base(8'd1, 3'd2, 1'b1, $urandom());
    send_base(8'd20, 3'd2, 1'b1, $urandom());
    drain();
  endtask

  initial begin
    for (int h = 0; h < NHAPS; h++) begin
      hap_cnt[h] = '0;
      rank_slot[h] = '0;
      for (int s = 0; s < NSITES; s++) hap_sym[h][s] = hsc_pkg::SYM_UNKNOWN;
    end
    for (int s = 0; s < NSITES; s++) read_buf[s] = hsc_pkg::SYM_UNKNOWN;
    n_used = 0;
    errors = 0;
    burst_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_reads(1700);
    test_table_full();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hsc_pkg.sv
rtl/hsc_ctrl.sv
rtl/hsc_dpath.sv
rtl/haplotype_string_clusterer.sv
bench/haplotype_string_clusterer_tb.sv
